FILE: sv/aavr_pkg.sv
// Package for the axis-angle rotation pipeline: widths, CORDIC constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aavr_pkg;
    localparam int CordicStages = 16;
    localparam int AtanEntries = 24;
    localparam int NumStages = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

    typedef logic signed [33:0] cord_t;
    typedef logic signed [31:0] ang_t;

    function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
        logic signed [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // carried alongside the CORDIC
    typedef struct packed {
        logic               fold;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } side_t;
endpackage
`default_nettype wire

FILE: sv/axis_angle_vector_rotation.sv
// Axis-angle vector rotation: a new item may be started every cycle (busy is always low);
// each result appears with done high for one cycle, after passing through the CORDIC
// pipeline and the five matrix stages. The receiver
// cannot stall, so results must be taken as they come.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_vector_rotation (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    input  wire logic signed [15:0] axis_x,
    input  wire logic signed [15:0] axis_y,
    input  wire logic signed [15:0] axis_z,
    input  wire logic [15:0]        angle,
    output logic                    done,
    output logic signed [31:0]      rot_x,
    output logic signed [31:0]      rot_y,
    output logic signed [31:0]      rot_z,
    output logic                    saturated
);
    import aavr_pkg::*;

    side_t side_in, side_c;
    logic  cv;
    cord_t c, s;

    assign busy = 1'b0;
    always_comb
    begin
        side_in.fold = 1'b0;
        side_in.vx   = vec_x;
        side_in.vy   = vec_y;
        side_in.vz   = vec_z;
        side_in.ax   = axis_x;
        side_in.ay   = axis_y;
        side_in.az   = axis_z;
    end

    aavr_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .angle(angle), .in_side(side_in),
        .out_valid(cv), .cos_q30(c), .sin_q30(s), .out_side(side_c)
    );

    aavr_matrix u_matrix (
        .clk(clk), .rst_n(rst_n), .in_valid(cv), .cos_q30(c), .sin_q30(s), .side(side_c),
        .out_valid(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
        .saturated(saturated)
    );
endmodule
`default_nettype wire

FILE: sv/aavr_cordic.sv
// CORDIC sine/cosine pipeline, one register stage per iteration, sideband carried along.
// Depends on aavr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aavr_cordic (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [15:0]   angle,
    input  wire aavr_pkg::side_t in_side,
    output logic               out_valid,
    output aavr_pkg::cord_t    cos_q30,
    output aavr_pkg::cord_t    sin_q30,
    output aavr_pkg::side_t    out_side
);
    import aavr_pkg::*;

    logic               valid_reg [NumStages+1];
    cord_t              x_reg [NumStages+1];
    cord_t              y_reg [NumStages+1];
    ang_t               z_reg [NumStages+1];
    side_t              side_reg [NumStages+1];

    logic        fold;
    logic [15:0] ang_f;
    side_t       side_f;

    assign fold  = angle[15] ^ angle[14];
    assign ang_f = fold ? (angle ^ 16'h8000) : angle;

    always_comb
    begin
        side_f      = in_side;
        side_f.fold = fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= CordicGain;
        y_reg[0]    <= '0;
        z_reg[0]    <= {ang_f, 16'h0000};
        side_reg[0] <= side_f;
    end

    for (genvar i = 0; i < NumStages; i++) begin : g_stage
        cord_t dx, dy;
        ang_t  at;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = atan_lut(5'(i));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else
                valid_reg[i+1] <= valid_reg[i];
        end
        always_ff @(posedge clk)
        begin
            side_reg[i+1] <= side_reg[i];
            if (!z_reg[i][31])
            begin
                x_reg[i+1] <= x_reg[i] - dy;
                y_reg[i+1] <= y_reg[i] + dx;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dy;
                y_reg[i+1] <= y_reg[i] - dx;
                z_reg[i+1] <= z_reg[i] + at;
            end
        end
    end

    // z of the last stage is not needed
    logic unused_z;
    assign unused_z = ^z_reg[NumStages];

    assign out_valid = valid_reg[NumStages];
    assign cos_q30   = side_reg[NumStages].fold ? -x_reg[NumStages] : x_reg[NumStages];
    assign sin_q30   = side_reg[NumStages].fold ? -y_reg[NumStages] : y_reg[NumStages];
    assign out_side  = side_reg[NumStages];
endmodule
`default_nettype wire

FILE: sv/aavr_matrix.sv
// Rodrigues matrix build and matrix-vector product with saturation, pipelined.
// Depends on aavr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aavr_matrix (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire aavr_pkg::cord_t cos_q30,
    input  wire aavr_pkg::cord_t sin_q30,
    input  wire aavr_pkg::side_t side,
    output logic               out_valid,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z,
    output logic               saturated
);
    import aavr_pkg::*;

    // stage A: a_i*a_j, cos term, a_k*sin
    logic              va_reg;
    logic signed [31:0] aa_reg [6];   // xx yy zz xy xz yz
    logic signed [49:0] as_reg [3];   // ax*s ay*s az*s
    cord_t              t_reg;
    logic signed [31:0] cr_reg;       // rnd(c,2)
    logic signed [31:0] va_v_reg [3];

    // stage B: a_i*a_j*t
    logic              vb_reg;
    logic signed [65:0] aat_reg [6];
    logic signed [33:0] sk_reg [3];
    logic signed [31:0] cb_reg;
    logic signed [31:0] vb_v_reg [3];

    // stage C: matrix entries
    logic              vc_reg;
    logic signed [35:0] m_reg [9];
    logic signed [31:0] vc_v_reg [3];

    // stage D: products rounded
    logic              vd_reg;
    logic signed [41:0] p_reg [9];

    // stage E: output
    logic              ve_reg;
    logic signed [31:0] r_reg [3];
    logic               sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    cord_t c2;
    assign c2 = (cos_q30 + 34'sd2) >>> 2;

    always_ff @(posedge clk)
    begin
        aa_reg[0] <= side.ax * side.ax;
        aa_reg[1] <= side.ay * side.ay;
        aa_reg[2] <= side.az * side.az;
        aa_reg[3] <= side.ax * side.ay;
        aa_reg[4] <= side.ax * side.az;
        aa_reg[5] <= side.ay * side.az;
        as_reg[0] <= 50'(side.ax) * 50'(sin_q30);
        as_reg[1] <= 50'(side.ay) * 50'(sin_q30);
        as_reg[2] <= 50'(side.az) * 50'(sin_q30);
        t_reg     <= OneQ30 - cos_q30;
        cr_reg    <= 32'(c2);
        va_v_reg[0] <= side.vx;
        va_v_reg[1] <= side.vy;
        va_v_reg[2] <= side.vz;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
            aat_reg[k] <= 66'(aa_reg[k]) * 66'(t_reg);
        for (int k = 0; k < 3; k++)
        begin
            sk_reg[k]   <= 34'((as_reg[k] + 50'sd32768) >>> 16);
            vb_v_reg[k] <= va_v_reg[k];
        end
        cb_reg <= cr_reg;
    end

    logic signed [65:0] q [6];
    always_comb
    begin
        for (int k = 0; k < 6; k++)
            q[k] = (aat_reg[k] + 66'sd536870912) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        m_reg[0] <= 36'(q[0]) + 36'(cb_reg);
        m_reg[4] <= 36'(q[1]) + 36'(cb_reg);
        m_reg[8] <= 36'(q[2]) + 36'(cb_reg);
        m_reg[1] <= 36'(q[3]) - 36'(sk_reg[2]);
        m_reg[3] <= 36'(q[3]) + 36'(sk_reg[2]);
        m_reg[2] <= 36'(q[4]) + 36'(sk_reg[1]);
        m_reg[6] <= 36'(q[4]) - 36'(sk_reg[1]);
        m_reg[5] <= 36'(q[5]) - 36'(sk_reg[0]);
        m_reg[7] <= 36'(q[5]) + 36'(sk_reg[0]);
        for (int k = 0; k < 3; k++)
            vc_v_reg[k] <= vb_v_reg[k];
    end

    logic signed [67:0] prod [9];
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            prod[k] = 68'(vc_v_reg[k % 3]) * 68'(m_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
            p_reg[k] <= 42'((prod[k] + 68'sd134217728) >>> 28);
    end

    logic signed [43:0] sum [3];
    logic [2:0]         hi, lo;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = 44'(p_reg[3*k]) + 44'(p_reg[3*k+1]) + 44'(p_reg[3*k+2]);
            hi[k]  = sum[k] > 44'sd2147483647;
            lo[k]  = sum[k] < -44'sd2147483648;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            r_reg[k] <= hi[k] ? 32'sh7FFFFFFF : (lo[k] ? 32'sh80000000 : sum[k][31:0]);
        sat_reg <= |{hi, lo};
    end

    assign out_valid = ve_reg;
    assign rot_x     = r_reg[0];
    assign rot_y     = r_reg[1];
    assign rot_z     = r_reg[2];
    assign saturated = sat_reg;
endmodule
`default_nettype wire

FILE: sv/aavr_checker.sv
// Port-level checks for axis_angle_vector_rotation, bound to the top level.
// Depends on aavr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aavr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] rot_x,
    input wire logic [31:0] rot_y,
    input wire logic [31:0] rot_z,
    input wire logic        saturated
);
    import aavr_pkg::*;

    localparam int Lat = NumStages + 6;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##Lat done) else $error("transfer lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, Lat)) else $error("unrequested result");
    // a clipped transfer carries at least one component at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (rot_x == 32'h7FFFFFFF || rot_x == 32'h80000000
        || rot_y == 32'h7FFFFFFF || rot_y == 32'h80000000
        || rot_z == 32'h7FFFFFFF || rot_z == 32'h80000000)) else $error("sat flag");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
endmodule

bind axis_angle_vector_rotation aavr_checker u_aavr_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .saturated(saturated)
);
`default_nettype wire

FILE: verif/tb_axis_angle_vector_rotation.sv
// Testbench for axis_angle_vector_rotation: directed and random rotations checked against
// a bit-exact predictor of the CORDIC and Rodrigues matrix arithmetic.
// Depends on aavr_pkg (stage count) and the block itself.
`timescale 1ns / 1ps
module tb_axis_angle_vector_rotation;
    import aavr_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sat;
    } rot_res_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic signed [15:0] axis_x, axis_y, axis_z;
    logic [15:0] angle;
    logic done;
    logic signed [31:0] rot_x, rot_y, rot_z;
    logic saturated;

    rot_res_t rotated_q[$];
    int errors;
    bit gaps_on;

    axis_angle_vector_rotation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .done(done), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic rot_res_t rotate(longint v[3], longint a[3], logic [15:0] ang);
        longint atan_v[24] = '{
            'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
            'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
        longint cx, cy, zz, dx, dy, c, s, t, r;
        longint m[3][3];
        logic [15:0] fa;
        bit fold;
        rot_res_t res;
        cx = 652032874;
        cy = 0;
        fa = ang + 16'h4000;
        fold = fa[15];
        fa = fold ? (ang ^ 16'h8000) : ang;
        zz = longint'($signed(fa)) * 65536;
        for (int i = 0; i < CordicStages && i < 24; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (zz >= 0)
            begin
                cx -= dx; cy += dy; zz -= atan_v[i];
            end
            else
            begin
                cx += dx; cy -= dy; zz += atan_v[i];
            end
        end
        c = fold ? -cx : cx;
        s = fold ? -cy : cy;
        t = (64'sd1 <<< 30) - c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = rnd_shift(a[i] * a[j] * t, 30);
        for (int i = 0; i < 3; i++)
            m[i][i] += rnd_shift(c, 2);
        m[0][1] -= rnd_shift(a[2] * s, 16);
        m[0][2] += rnd_shift(a[1] * s, 16);
        m[1][0] += rnd_shift(a[2] * s, 16);
        m[1][2] -= rnd_shift(a[0] * s, 16);
        m[2][0] -= rnd_shift(a[1] * s, 16);
        m[2][1] += rnd_shift(a[0] * s, 16);
        res.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            r = 0;
            for (int j = 0; j < 3; j++)
                r += rnd_shift(v[j] * m[i][j], 28);
            if (r > 64'sd2147483647)
            begin
                r = 64'sd2147483647; res.sat = 1'b1;
            end
            else if (r < -64'sd2147483648)
            begin
                r = -64'sd2147483648; res.sat = 1'b1;
            end
            if (i == 0) res.x = r[31:0];
            else if (i == 1) res.y = r[31:0];
            else res.z = r[31:0];
        end
        return res;
    endfunction

    // one transfer; start stays high across back-to-back items
    task automatic send_rotation(logic signed [31:0] vx, logic signed [31:0] vy,
                                 logic signed [31:0] vz, logic signed [15:0] ax,
                                 logic signed [15:0] ay, logic signed [15:0] az,
                                 logic [15:0] ang);
        longint v[3];
        longint a[3];
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vec_x <= vx; vec_y <= vy; vec_z <= vz;
        axis_x <= ax; axis_y <= ay; axis_z <= az; angle <= ang;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        v[0] = vx; v[1] = vy; v[2] = vz;
        a[0] = ax; a[1] = ay; a[2] = az;
        rotated_q.push_back(rotate(v, a, ang));
        @(negedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (rotated_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_axis;
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return -16'sd32768;
            3: return $signed(16'($urandom()));
            default: return $signed(16'($urandom_range(0, 32768) - 16384));
        endcase
    endfunction

    function automatic logic signed [31:0] rand_vec;
        case ($urandom_range(0, 4))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(0, 32'h00200000)) - 32'h00100000);
            default: return $signed(32'($urandom()));
        endcase
    endfunction

    task automatic test_directed;
        logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h3FFF, 16'h8000,
                                 16'hBFFF, 16'hC000, 16'hFFFF, 16'h2000};
        foreach (angs[k])
            send_rotation(32'sh00010000, 32'sh00020000, -32'sh00030000,
                          16'sd0, 16'sd0, 16'sd16384, angs[k]);
        // extremes of vector and axis, including the -2.0 axis value
        send_rotation(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                      16'sd16384, 16'sd16384, 16'sd16384, 16'h8000);
        send_rotation(32'sh80000000, 32'sh80000000, 32'sh80000000,
                      -16'sd32768, -16'sd32768, -16'sd32768, 16'h4000);
        send_rotation(32'sh80000000, 32'sh7FFFFFFF, 32'sh0,
                      16'sh7FFF, -16'sd16384, 16'sd16384, 16'hFFFF);
        send_rotation(32'sh0, 32'sh0, 32'sh0, 16'sd0, 16'sd0, 16'sd0, 16'h1234);
        send_rotation(32'shFFFFFFFF, 32'sh1, 32'sh00008000,
                      16'sd9459, 16'sd9459, 16'sd9459, 16'h5555);
        send_rotation(32'sh40000000, -32'sh40000000, 32'sh40000000,
                      16'sd16384, 16'sd0, 16'sd0, 16'h6000);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            send_rotation(rand_vec(), rand_vec(), rand_vec(), rand_axis(), rand_axis(),
                          rand_axis(), 16'($urandom()));
    endtask

    // checker: one transfer per done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h z=%h", $time, rot_x, rot_y, rot_z);
                errors++;
            end
            else
            begin
                rot_res_t e;
                e = rotated_q.pop_front();
                if (rot_x !== e.x)
                begin
                    $display("%0t: rot_x expected %h actual %h", $time, e.x, rot_x);
                    errors++;
                end
                if (rot_y !== e.y)
                begin
                    $display("%0t: rot_y expected %h actual %h", $time, e.y, rot_y);
                    errors++;
                end
                if (rot_z !== e.z)
                begin
                    $display("%0t: rot_z expected %h actual %h", $time, e.z, rot_z);
                    errors++;
                end
                if (saturated !== e.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, e.sat, saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        errors = 0;
        gaps_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        vec_x = '0; vec_y = '0; vec_z = '0;
        axis_x = '0; axis_y = '0; axis_z = '0; angle = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        drain();
        test_random(1400);
        drain();
        gaps_on = 1'b0;
        test_random(450);
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

FILE: filelist.f
sv/aavr_pkg.sv
sv/aavr_cordic.sv
sv/aavr_matrix.sv
sv/axis_angle_vector_rotation.sv
sv/aavr_checker.sv
verif/tb_axis_angle_vector_rotation.sv
